// ----- rtl/md2_pkg.sv -----
// shared types, constants and s-box table for the md2 hash engine
`timescale 1ns / 1ps

package md2_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int MIX_BYTES   = 48;
  localparam int ROUNDS      = 18;
  localparam int Q_DEPTH     = 4;

  typedef logic [7:0] byte_t;

  // class of a word after the front end has looked at it
  typedef enum logic [0:0] {
    CLS_DATA   = 1'b0,
    CLS_FINISH = 1'b1
  } cls_t;

  // one queued word: class, end-of-block flag, byte slot and message byte
  typedef struct packed {
    cls_t       cls;
    logic       blk_last;
    logic [3:0] idx;
    byte_t      data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_MIX,
    ST_FOLD,
    ST_CSLOAD,
    ST_EMIT
  } state_t;

  localparam byte_t SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  function automatic byte_t sbox(input byte_t x);
    return SBOX[x];
  endfunction

endpackage

// ----- rtl/md2_front.sv -----
// front end: accepts words, tracks the block fill and tags each word
`timescale 1ns / 1ps

module md2_front
  import md2_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_kind,
  input  byte_t in_data_byte,
  input  logic  q_full,
  output logic  q_push,
  output item_t q_item
);

  logic [3:0] fill_r;
  logic [3:0] fill_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.cls      = in_kind ? CLS_FINISH : CLS_DATA;
    q_item.idx      = fill_r;
    q_item.blk_last = !in_kind && (fill_r == 4'(BLOCK_BYTES - 1));
    q_item.data     = in_data_byte;
    fill_nxt        = fill_r;
    if (q_push) begin
      fill_nxt = in_kind ? 4'd0 : fill_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a finish word always restarts the block fill
  a_finish_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_kind) |=> (fill_r == 4'd0))
    else $error("fill count not cleared after finish");
`endif

endmodule

// ----- rtl/md2_fifo.sv -----
// small word queue between front end and core
`timescale 1ns / 1ps

module md2_fifo
  import md2_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy follows the push and pop strobes
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/md2_core.sv -----
// back end: block buffer, 48-byte mix rotation, checksum fold and digest output
`timescale 1ns / 1ps

module md2_core
  import md2_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_digest_byte,
  output logic  out_last_byte
);

  state_t     state_r;
  state_t     state_nxt;
  byte_t      ms_r  [MIX_BYTES];
  byte_t      cs_r  [BLOCK_BYTES];
  byte_t      buf_r [BLOCK_BYTES];
  byte_t      t_r;
  byte_t      l_r;
  logic [5:0] cnt_r;
  logic [4:0] rnd_r;
  logic [3:0] fill_r;
  logic       fin_r;
  logic       second_r;
  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_last_r;

  logic       mix_end;
  logic       out_load;
  byte_t      mix_v;
  byte_t      fold_v;
  byte_t      pad;

  assign mix_end  = (cnt_r == 6'(MIX_BYTES - 1)) && (rnd_r == 5'(ROUNDS - 1));
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign mix_v    = ms_r[0] ^ sbox(t_r);
  assign fold_v   = cs_r[0] ^ sbox(buf_r[cnt_r[3:0]] ^ l_r);
  assign pad      = 8'(BLOCK_BYTES) - {4'd0, fill_r};

  assign out_valid       = out_valid_r;
  assign out_digest_byte = out_byte_r;
  assign out_last_byte   = out_last_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.cls == CLS_FINISH) begin
            state_nxt = ST_PAD;
          end else if (q_item.blk_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_PAD:    state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_MIX;
      ST_MIX: begin
        if (mix_end) begin
          state_nxt = second_r ? ST_EMIT : ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cnt_r[3:0] == 4'(BLOCK_BYTES - 1)) begin
          state_nxt = fin_r ? ST_CSLOAD : ST_IDLE;
        end
      end
      ST_CSLOAD: state_nxt = ST_LOAD;
      ST_EMIT: begin
        if (out_load && cnt_r[3:0] == 4'(BLOCK_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // block buffer: written by data words, padding and the checksum copy
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_pop && q_item.cls == CLS_DATA) begin
          buf_r[q_item.idx] <= q_item.data;
        end
      end
      ST_PAD: begin
        for (int j = 0; j < BLOCK_BYTES; j++) begin
          if (4'(j) >= fill_r) begin
            buf_r[j] <= pad;
          end
        end
      end
      ST_CSLOAD: begin
        for (int j = 0; j < BLOCK_BYTES; j++) begin
          buf_r[j] <= cs_r[j];
        end
      end
      default: ;
    endcase
  end

  // mix state, checksum, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MIX_BYTES; k++) begin
        ms_r[k] <= 8'd0;
      end
      for (int k = 0; k < BLOCK_BYTES; k++) begin
        cs_r[k] <= 8'd0;
      end
      t_r         <= 8'd0;
      l_r         <= 8'd0;
      cnt_r       <= 6'd0;
      rnd_r       <= 5'd0;
      fill_r      <= 4'd0;
      fin_r       <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            fin_r    <= (q_item.cls == CLS_FINISH);
            fill_r   <= q_item.idx;
            second_r <= 1'b0;
          end
        end
        ST_LOAD: begin
          for (int j = 0; j < BLOCK_BYTES; j++) begin
            ms_r[BLOCK_BYTES + j]     <= buf_r[j];
            ms_r[2 * BLOCK_BYTES + j] <= ms_r[j] ^ buf_r[j];
          end
          t_r   <= 8'd0;
          l_r   <= cs_r[BLOCK_BYTES - 1];
          cnt_r <= 6'd0;
          rnd_r <= 5'd0;
        end
        ST_MIX: begin
          for (int k = 0; k < MIX_BYTES - 1; k++) begin
            ms_r[k] <= ms_r[k + 1];
          end
          ms_r[MIX_BYTES - 1] <= mix_v;
          if (cnt_r == 6'(MIX_BYTES - 1)) begin
            t_r   <= mix_v + {3'd0, rnd_r};
            cnt_r <= 6'd0;
            rnd_r <= rnd_r + 5'd1;
          end else begin
            t_r   <= mix_v;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_FOLD: begin
          for (int k = 0; k < BLOCK_BYTES - 1; k++) begin
            cs_r[k] <= cs_r[k + 1];
          end
          cs_r[BLOCK_BYTES - 1] <= fold_v;
          l_r   <= fold_v;
          cnt_r <= (cnt_r[3:0] == 4'(BLOCK_BYTES - 1)) ? 6'd0 : cnt_r + 6'd1;
        end
        ST_CSLOAD: begin
          second_r <= 1'b1;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_byte_r  <= ms_r[0];
            out_last_r  <= (cnt_r[3:0] == 4'(BLOCK_BYTES - 1));
            if (cnt_r[3:0] == 4'(BLOCK_BYTES - 1)) begin
              // digest taken: clear for the next message
              for (int k = 0; k < MIX_BYTES; k++) begin
                ms_r[k] <= 8'd0;
              end
              for (int k = 0; k < BLOCK_BYTES; k++) begin
                cs_r[k] <= 8'd0;
              end
              cnt_r <= 6'd0;
            end else begin
              for (int k = 0; k < MIX_BYTES - 1; k++) begin
                ms_r[k] <= ms_r[k + 1];
              end
              ms_r[MIX_BYTES - 1] <= ms_r[0];
              cnt_r <= cnt_r + 6'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // round counter never runs past the last round while mixing
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> (rnd_r < 5'(ROUNDS)))
    else $error("mix round counter out of range");

  // the core pulls a queued word only when idle and the queue has one
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !q_empty))
    else $error("queue popped outside idle");

  // after the last digest byte the message state is cleared
  a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && cnt_r[3:0] == 4'(BLOCK_BYTES - 1))
      |=> (ms_r[0] == 8'd0 && cs_r[0] == 8'd0 && out_last_r && out_valid_r))
    else $error("state not cleared after digest");
`endif

endmodule

// ----- rtl/md2_hash_engine.sv -----
// top level of the md2 hash engine: front end, word queue and mixing core
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | in_kind, in_data_byte
//  out_    | output    | out_valid/out_ready | out_digest_byte, out_last_byte
//
//  a data word is written into the block buffer; the sixteenth word of a block also
//  starts the load, 18 mix rounds over the 48-byte state and the 16-byte checksum fold,
//  paced by the serial s-box chain through the 48-byte mix rotation
//  a finish word pads the block, runs it and then the checksum block, and emits 16 bytes
//  synchronous active-low reset clears all control, mix state and checksum
//  input stalls only when the word queue is full; the output register
//  holds the current digest byte until taken and stalls only the emit phase
module md2_hash_engine
  import md2_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_kind,
  input  byte_t in_data_byte,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_digest_byte,
  output logic  out_last_byte
);

  // front end to queue
  logic  q_push;
  logic  q_full;
  item_t push_item;

  // queue to core
  logic  q_pop;
  logic  q_empty;
  item_t pop_item;

  // front end: block fill tracking and word classification
  md2_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // decoupling queue so input words keep flowing while a block is mixed, until it is full
  md2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  // mixing core: block buffer, 48-byte rotation, checksum and digest
  md2_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_byte (out_digest_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule
